### hw/rtl/ttip_pkg.sv
// shared constants, types and digit decode for the text to integer parser
`default_nettype none

package ttip_pkg;

    // parse phase codes
    typedef logic [1:0] t_phase;
    localparam t_phase PH_SIGN   = 2'd0;
    localparam t_phase PH_ZERO   = 2'd1;
    localparam t_phase PH_X      = 2'd2;
    localparam t_phase PH_DIGITS = 2'd3;

    // field widths
    localparam int unsigned CH_W    = 8;
    localparam int unsigned RADIX_W = 6;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned COUNT_W = 4;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 40;

    // characters and radix values
    localparam logic [CH_W-1:0]    CH_MINUS    = 8'h2D;
    localparam logic [CH_W-1:0]    CH_ZERO     = 8'h30;
    localparam logic [CH_W-1:0]    CH_LOWER_X  = 8'h78;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;

    // decoded digit: ok is low for a byte that is no digit
    typedef struct packed {
        logic               ok;
        logic [RADIX_W-1:0] val;
    } t_digit;

    // map '0'-'9', 'A'-'Z', 'a'-'z' to 0..35
    function automatic t_digit digit_of(input logic [CH_W-1:0] c);
        t_digit d;
        d.ok  = 1'b1;
        d.val = '0;
        case (c) inside
            [8'h30:8'h39]: d.val = RADIX_W'(c - 8'h30);
            [8'h41:8'h5A]: d.val = RADIX_W'(c - 8'h41 + 8'd10);
            [8'h61:8'h7A]: d.val = RADIX_W'(c - 8'h61 + 8'd10);
            default:       d.ok  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/text_to_integer_parser.sv
// streaming ascii to integer parser with sign and hex prefix handling
// an accepted item is held in the input register; the result it ends is held in the result register
// throughput: one item per cycle while the output is not stalled; the multiply-accumulate is combinational
// a stalled output holds the item in the input register; input ready is high while it is empty or the stage advances
// reset: synchronous active low, clears the parse state and both valid flags
`default_nettype none

module text_to_integer_parser #(
    parameter int unsigned MAX_DIGITS = 9
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // item in
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] ch, [13:8] radix, [15:14] zero
    input  wire  [ttip_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] start_req
    input  wire                               s_axis_tuser,
    // result out
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [31:0] value, [35:32] consumed_length, [39:36] zero
    output logic [ttip_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    import ttip_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

    // input register
    logic                  r_in_valid;
    logic                  r_start;
    logic [CH_W-1:0]       r_ch;
    logic [RADIX_W-1:0]    r_radix;

    // parse state
    logic                  r_busy;
    logic                  r_neg;
    logic [VALUE_W-1:0]    r_acc;
    logic [COUNT_W-1:0]    r_dcnt;
    logic [COUNT_W-1:0]    r_bcnt;
    t_phase                r_phase;
    logic [RADIX_W-1:0]    r_act_radix;

    // next state
    logic                  n_busy;
    logic                  n_neg;
    logic [VALUE_W-1:0]    n_acc;
    logic [COUNT_W-1:0]    n_dcnt;
    logic [COUNT_W-1:0]    n_bcnt;
    t_phase                n_phase;
    logic [RADIX_W-1:0]    n_act_radix;
    logic                  n_emit;
    logic [VALUE_W-1:0]    n_value;

    // result register
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_value;
    logic [LEN_W-1:0]      r_out_len;

    logic                  fire;
    t_digit                dig;

    // the work stage advances when the result register is free or drains
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign dig           = digit_of(r_ch);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_start <= s_axis_tuser;
            r_ch    <= s_axis_tdata[CH_W-1:0];
            r_radix <= s_axis_tdata[CH_W+RADIX_W-1:CH_W];
        end
    end

    // one parse step on the registered byte
    always_comb begin
        logic done;
        done        = 1'b0;
        n_emit      = 1'b0;
        n_busy      = r_busy;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_dcnt      = r_dcnt;
        n_bcnt      = r_bcnt;
        n_phase     = r_phase;
        n_act_radix = r_act_radix;

        // start byte opens a new number, abandoning any in progress
        if (r_start) begin
            n_busy      = 1'b1;
            n_neg       = 1'b0;
            n_acc       = '0;
            n_dcnt      = '0;
            n_bcnt      = '0;
            n_phase     = PH_SIGN;
            n_act_radix = r_radix;
        end else if (!r_busy) begin
            done = 1'b1;
        end

        // optional leading minus
        if (!done && n_phase == PH_SIGN) begin
            n_phase = PH_ZERO;
            if (r_ch == CH_MINUS) begin
                n_neg  = 1'b1;
                n_bcnt = COUNT_W'(1);
                done   = 1'b1;
            end
        end

        // leading zero and hex prefix
        if (!done) begin
            if (n_phase == PH_ZERO) begin
                if (r_ch == CH_ZERO) begin
                    n_phase = PH_X;
                    done    = 1'b1;
                end else begin
                    n_phase = PH_DIGITS;
                end
            end else if (n_phase == PH_X) begin
                n_phase = PH_DIGITS;
                if (r_ch == CH_LOWER_X) begin
                    n_act_radix = RADIX_HEX;
                    n_bcnt      = n_bcnt + COUNT_W'(2);
                    done        = 1'b1;
                end else begin
                    // the held zero counts as the first digit
                    n_acc  = '0;
                    n_dcnt = COUNT_W'(1);
                    n_bcnt = n_bcnt + COUNT_W'(1);
                    if (n_dcnt >= MAX_CNT) begin
                        n_emit = 1'b1;
                        done   = 1'b1;
                    end
                end
            end
        end

        // digit multiply-accumulate or terminator
        if (!done) begin
            if (!dig.ok) begin
                n_emit = 1'b1;
            end else begin
                n_acc  = n_acc * {{(VALUE_W-RADIX_W){1'b0}}, n_act_radix}
                         + {{(VALUE_W-RADIX_W){1'b0}}, dig.val};
                n_dcnt = n_dcnt + COUNT_W'(1);
                n_bcnt = n_bcnt + COUNT_W'(1);
                if (n_dcnt >= MAX_CNT) begin
                    n_emit = 1'b1;
                end
            end
        end

        if (n_emit) begin
            n_busy = 1'b0;
        end
        n_value = n_neg ? (VALUE_W'(0) - n_acc) : n_acc;
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_dcnt      <= '0;
            r_bcnt      <= '0;
            r_phase     <= PH_SIGN;
            r_act_radix <= RADIX_RESET;
        end else if (fire) begin
            r_busy      <= n_busy;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_dcnt      <= n_dcnt;
            r_bcnt      <= n_bcnt;
            r_phase     <= n_phase;
            r_act_radix <= n_act_radix;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (fire && n_emit) begin
            r_out_value <= n_value;
            r_out_len   <= n_bcnt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-VALUE_W-LEN_W){1'b0}}, r_out_len, r_out_value};

endmodule

`default_nettype wire

### hw/rtl/ttip_checker.sv
// port level checks for the text to integer parser, bound to the top level
`default_nettype none

module ttip_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [ttip_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    import ttip_pkg::*;

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // sign, prefix and digits never exceed twelve bytes
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[VALUE_W+LEN_W-1:VALUE_W] <= LEN_W'(12))
        else $error("consumed length out of range");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:VALUE_W+LEN_W] == '0)
        else $error("result padding not zero");

endmodule

bind text_to_integer_parser ttip_checker u_ttip_checker (.*);

`default_nettype wire
